// ===== sv/pixel_color_adjust_defines.svh =====
// ----------------------------------------------------------------------------
// pixel_color_adjust_defines.svh
// Assertion macros shared by the pixel color adjust RTL.
// ----------------------------------------------------------------------------
// PCA_ASSERT checks a property on clk while rst_n is high.
// PCA_ASSERT_RST checks a property on clk at every edge, during reset too.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef PIXEL_COLOR_ADJUST_DEFINES_SVH
`define PIXEL_COLOR_ADJUST_DEFINES_SVH

`ifndef SYNTHESIS
`define PCA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pixel_color_adjust assertion failed");
`define PCA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pixel_color_adjust reset assertion failed");
`else
`define PCA_ASSERT(lbl, prop)
`define PCA_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== sv/pca_pkg.sv =====
// ----------------------------------------------------------------------------
// pca_pkg
// Types and constants of the pixel color adjust block.
// ----------------------------------------------------------------------------
`default_nettype none

package pca_pkg;

  // Operating modes held in the mode register.
  localparam logic [2:0] MODE_BRIGHT   = 3'd0;
  localparam logic [2:0] MODE_CONTRAST = 3'd1;
  localparam logic [2:0] MODE_SAT      = 3'd2;
  localparam logic [2:0] MODE_GRAY     = 3'd3;
  localparam logic [2:0] MODE_INVERT   = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE     = 2'd0;
  localparam logic [1:0] CFG_FACTOR   = 2'd1;
  localparam logic [1:0] CFG_CHANNELS = 2'd2;

  // BT.601 luma weights, Q0.16. They sum to exactly 65536.
  localparam logic [15:0] LUMA_WR = 16'd19595;
  localparam logic [15:0] LUMA_WG = 16'd38470;
  localparam logic [15:0] LUMA_WB = 16'd7471;

  // Number of color lanes that do arithmetic; channel 3 is alpha.
  localparam int COLOR_LANES = 3;

  // Operation a color lane performs.
  localparam logic [1:0] LANE_BRIGHT   = 2'd0;
  localparam logic [1:0] LANE_CONTRAST = 2'd1;
  localparam logic [1:0] LANE_SAT      = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] factor;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== sv/pca_luma.sv =====
// ----------------------------------------------------------------------------
// pca_luma
// Registered BT.601 luma of one pixel, weights Q0.16, result unscaled.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_luma (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  output logic      [23:0] y16
);

  logic [23:0] y16_r;
  logic [23:0] y16_nxt;

  // The weights sum to 65536, so the weighted sum of 8-bit values fits 24 bits.
  assign y16_nxt = pca_pkg::LUMA_WR * red + pca_pkg::LUMA_WG * green
                 + pca_pkg::LUMA_WB * blue;

  always_ff @(posedge clk) begin
    if (en) begin
      y16_r <= y16_nxt;
    end
  end

  assign y16 = y16_r;

endmodule

`default_nettype wire

// ===== sv/pca_lane.sv =====
// ----------------------------------------------------------------------------
// pca_lane
// One color lane: operand select and signed multiply, registered, then the
// bias add and clamp to 0..255.
// ----------------------------------------------------------------------------
`default_nettype none

module pca_lane (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire pca_pkg::lane_ctl_t  ctl,
  input  wire logic [7:0]          sample,
  input  wire logic [23:0]         y16,
  output logic      [7:0]          value
);

  logic signed [24:0] operand;
  logic signed [40:0] prod_nxt;
  logic signed [40:0] prod_r;
  logic signed [32:0] bias_nxt;
  logic signed [32:0] bias_r;
  logic               wide_nxt;
  logic               wide_r;
  logic signed [41:0] sum;
  logic signed [41:0] shifted;

  // Saturation works on v*65536 - Y16 with a Q24 result; the others are Q8.
  always_comb begin
    case (ctl.op)
      pca_pkg::LANE_CONTRAST: begin
        operand  = $signed({17'd0, sample}) - 25'sd128;
        bias_nxt = 33'sd32896;
        wide_nxt = 1'b0;
      end
      pca_pkg::LANE_SAT: begin
        operand  = $signed({1'b0, sample, 16'd0}) - $signed({1'b0, y16});
        bias_nxt = $signed({1'b0, y16, 8'd0});
        wide_nxt = 1'b1;
      end
      default: begin
        operand  = $signed({17'd0, sample});
        bias_nxt = 33'sd0;
        wide_nxt = 1'b0;
      end
    endcase
  end

  assign prod_nxt = operand * ctl.factor;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      bias_r <= bias_nxt;
      wide_r <= wide_nxt;
    end
  end

  assign sum     = {prod_r[40], prod_r} + {{9{bias_r[32]}}, bias_r};
  assign shifted = wide_r ? (sum >>> 24) : (sum >>> 8);

  // A negative sum clamps to zero, so the arithmetic shift needs no rounding fix.
  always_comb begin
    if (sum[41]) begin
      value = 8'd0;
    end else if (shifted > 42'sd255) begin
      value = 8'd255;
    end else begin
      value = shifted[7:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/pixel_color_adjust.sv =====
// ----------------------------------------------------------------------------
// pixel_color_adjust
// Per-pixel brightness, contrast, saturation, grayscale and invert on a
// stream of pixels with up to four 8-bit channels.
// ----------------------------------------------------------------------------
// Flow: an accepted beat passes the stage 1, stage 2 and stage 3 registers in
//   turn before it shows on out_tvalid; a stall on the output side holds it.
// Throughput: one pixel per cycle while the output side does not stall, set by
//   the three color lanes, each with one signed 25x16 multiplier per pixel.
// Reset: rst_n is synchronous and active low; it empties the pipeline and
//   loads mode 0, factor 256 (1.0) and a channel count of 4.
`default_nettype none

`include "pixel_color_adjust_defines.svh"

module pixel_color_adjust (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  // Input pixel stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // sample0, sample1, sample2, sample3
  // Output pixel stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata   // result0..result3, result_channels, zero pad
);

  // --------------------------------------------------------------------------
  // Configuration registers. The user must see they are only written while
  // the pipeline is empty, so every stage reads them directly; nothing enforces it.
  // --------------------------------------------------------------------------
  logic [2:0]         mode_r;
  logic signed [15:0] factor_r;
  logic [2:0]         chan_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= pca_pkg::MODE_BRIGHT;
      factor_r   <= 16'sd256;
      chan_cnt_r <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_addr)
        pca_pkg::CFG_MODE:     mode_r     <= cfg_wdata[2:0];
        pca_pkg::CFG_FACTOR:   factor_r   <= $signed(cfg_wdata);
        pca_pkg::CFG_CHANNELS: chan_cnt_r <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  // A count of zero acts as one and anything above four acts as four.
  logic [2:0] n_eff;
  logic [2:0] lim;

  always_comb begin
    if (chan_cnt_r == 3'd0) begin
      n_eff = 3'd1;
    end else if (chan_cnt_r > 3'd4) begin
      n_eff = 3'd4;
    end else begin
      n_eff = chan_cnt_r;
    end
    lim = (n_eff < 3'd3) ? n_eff : 3'd3;
  end

  // --------------------------------------------------------------------------
  // Pipeline flow. Each stage loads when it is empty or the stage after it
  // moves, so bubbles are squeezed out and the input keeps taking beats while
  // a finished pixel waits at the output, until the earlier stages are full.
  // --------------------------------------------------------------------------
  logic v1_r;
  logic v2_r;
  logic out_valid_r;
  logic adv1;
  logic adv2;
  logic adv3;

  assign adv3 = !out_valid_r || out_tready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_tready  = adv1;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_tvalid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture the samples and form the luma.
  // --------------------------------------------------------------------------
  logic [7:0]  s1_r [4];
  logic [23:0] y16;
  logic        load1;

  assign load1 = adv1 && in_tvalid;

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_r[0] <= in_tdata[7:0];
      s1_r[1] <= in_tdata[15:8];
      s1_r[2] <= in_tdata[23:16];
      s1_r[3] <= in_tdata[31:24];
    end
  end

  pca_luma u_luma (
    .clk   (clk),
    .en    (load1),
    .red   (in_tdata[7:0]),
    .green (in_tdata[15:8]),
    .blue  (in_tdata[23:16]),
    .y16   (y16)
  );

  // --------------------------------------------------------------------------
  // Stage 2: the three color lanes multiply side by side. The samples and the
  // rounded luma travel along for the modes that need no multiply.
  // --------------------------------------------------------------------------
  pca_pkg::lane_ctl_t lane_ctl;
  logic               load2;
  logic [7:0]         s2_r [4];
  logic [7:0]         gray2_r;
  logic [23:0]        gray_sum;
  logic [7:0]         lane_val [pca_pkg::COLOR_LANES];

  assign load2 = adv2 && v1_r;

  always_comb begin
    lane_ctl.factor = factor_r;
    case (mode_r)
      pca_pkg::MODE_CONTRAST: lane_ctl.op = pca_pkg::LANE_CONTRAST;
      pca_pkg::MODE_SAT:      lane_ctl.op = pca_pkg::LANE_SAT;
      default:                lane_ctl.op = pca_pkg::LANE_BRIGHT;
    endcase
  end

  // Luma rounded half up; the sum stays below 2^24 for any 8-bit pixel.
  assign gray_sum = y16 + 24'd32768;

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_r    <= s1_r;
      gray2_r <= gray_sum[23:16];
    end
  end

  for (genvar g = 0; g < pca_pkg::COLOR_LANES; g++) begin : g_lane
    pca_lane u_lane (
      .clk    (clk),
      .en     (load2),
      .ctl    (lane_ctl),
      .sample (s1_r[g]),
      .y16    (y16),
      .value  (lane_val[g])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 3: merge. Each output channel picks the lane result, the inverted
  // or unchanged sample, the luma, or zero, and the result is registered.
  // --------------------------------------------------------------------------
  logic [7:0] res_nxt [4];
  logic [2:0] chans_nxt;
  logic [7:0] res_r [4];
  logic [2:0] chans_r;

  always_comb begin
    chans_nxt = n_eff;
    for (int c = 0; c < 4; c++) begin
      res_nxt[c] = (3'(c) < n_eff) ? s2_r[c] : 8'd0;
      case (mode_r)
        pca_pkg::MODE_BRIGHT, pca_pkg::MODE_CONTRAST: begin
          if (3'(c) < lim) begin
            res_nxt[c] = lane_val[c[1:0]];
          end
        end
        pca_pkg::MODE_SAT: begin
          // Saturation needs all three colors; otherwise the pixel passes.
          if (c < pca_pkg::COLOR_LANES && n_eff >= 3'd3) begin
            res_nxt[c] = lane_val[c[1:0]];
          end
        end
        pca_pkg::MODE_GRAY: begin
          if (c == 0) begin
            res_nxt[c] = (n_eff >= 3'd3) ? gray2_r : s2_r[0];
          end else begin
            res_nxt[c] = 8'd0;
          end
        end
        pca_pkg::MODE_INVERT: begin
          if (3'(c) < lim) begin
            res_nxt[c] = 8'd255 - s2_r[c];
          end
        end
        default: begin
        end
      endcase
    end
    if (mode_r == pca_pkg::MODE_GRAY) begin
      chans_nxt = 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      res_r   <= res_nxt;
      chans_r <= chans_nxt;
    end
  end

  assign out_tdata = {5'd0, chans_r, res_r[3], res_r[2], res_r[1], res_r[0]};

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `PCA_ASSERT_RST(a_reset_empties, !rst_n |=> !v1_r && !v2_r && !out_valid_r)
  `PCA_ASSERT(a_full_blocks_input, v1_r && v2_r && out_valid_r && !out_tready |-> !in_tready)
  `PCA_ASSERT(a_gray_one_channel,
              out_valid_r && mode_r == pca_pkg::MODE_GRAY
              |-> chans_r == 3'd1 && out_tdata[31:8] == 24'd0)
  `PCA_ASSERT(a_alpha_zero_past_count,
              out_valid_r && n_eff != 3'd4 |-> out_tdata[31:24] == 8'd0)

endmodule

`default_nettype wire

// ===== verif/pixel_color_adjust_tb.sv =====
// ----------------------------------------------------------------------------
// pixel_color_adjust_tb
// Self-checking testbench for the pixel color adjust block. A behavioral
// predictor mirrors the three registers and computes the expected pixel for
// every accepted input beat. A monitor compares each output beat, field by
// field, with the oldest expected pixel. Directed pixels cover the factor
// extremes, every mode and the channel-count corner cases. Random phases then
// change the whole configuration between bursts of random pixels, with random
// gaps on the input side and random back-pressure on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_color_adjust_tb;

  // A stall of this many cycles with no beat on either side ends the run.
  localparam int STALL_LIMIT = 1000;
  // Cycles to let pass after the last expected pixel before touching the
  // registers or ending the run; the pipeline is three stages deep.
  localparam int DRAIN_CYCLES = 8;
  // One of the unused mode codes; the block must pass such pixels unchanged.
  localparam logic [2:0] MODE_SPARE = 3'd7;

  // Output beat layout, result0 in the lowest bits.
  typedef struct packed {
    logic [2:0] channels;
    logic [7:0] r3;
    logic [7:0] r2;
    logic [7:0] r1;
    logic [7:0] r0;
  } pixel_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // sample0, sample1, sample2, sample3
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // result0..result3, result_channels, zero pad

  // Mirror of the block's registers, starting at their reset values.
  logic [2:0]         cur_mode = pca_pkg::MODE_BRIGHT;
  logic signed [15:0] cur_factor = 16'sd256;
  logic [2:0]         cur_chans = 3'd4;

  pixel_out_t expected_pixels[$];
  bit         idle_on = 1'b1;
  int         mismatches = 0;
  int         pixels_sent = 0;
  int         pixels_checked = 0;
  int         settings_used = 0;
  int         stall_cycles = 0;

  pixel_color_adjust dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial forever #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Takes a scaled intermediate, drops the fraction bits and clamps to a byte.
  // Anything negative clamps to zero, so flooring matches the hardware.
  function automatic logic [7:0] clamp_shift(input longint x, input int sh);
    longint q;
    if (x < 0) return 8'd0;
    q = x >>> sh;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic pixel_out_t predict_pixel(input logic [31:0] px);
    logic [7:0] smp [4];
    logic [7:0] res [4];
    int         n;
    int         lim;
    longint     f;
    longint     y16;
    pixel_out_t o;
    // A channel count of zero behaves as one, anything above four as four.
    n = (cur_chans == 3'd0) ? 1 : (cur_chans > 3'd4) ? 4 : int'(cur_chans);
    // Only the first three channels carry color; channel 3 is alpha.
    lim = (n < 3) ? n : 3;
    f = longint'(cur_factor);
    for (int c = 0; c < 4; c++) begin
      smp[c] = px[8*c +: 8];
      res[c] = (c < n) ? smp[c] : 8'd0;
    end
    // Luma with Q0.16 weights; the weights add up to exactly 1.0.
    y16 = longint'(pca_pkg::LUMA_WR) * longint'(smp[0])
        + longint'(pca_pkg::LUMA_WG) * longint'(smp[1])
        + longint'(pca_pkg::LUMA_WB) * longint'(smp[2]);
    case (cur_mode)
      pca_pkg::MODE_BRIGHT: begin
        for (int c = 0; c < lim; c++) res[c] = clamp_shift(longint'(smp[c]) * f, 8);
      end
      pca_pkg::MODE_CONTRAST: begin
        // Pivot around mid-gray, then round half up.
        for (int c = 0; c < lim; c++)
          res[c] = clamp_shift((longint'(smp[c]) - 128) * f + 128 * 256 + 128, 8);
      end
      pca_pkg::MODE_SAT: begin
        // Blend toward or away from luma; needs a full color pixel.
        if (n >= 3) begin
          for (int c = 0; c < 3; c++)
            res[c] = clamp_shift(y16 * 256 + (longint'(smp[c]) * 65536 - y16) * f, 24);
        end
      end
      pca_pkg::MODE_GRAY: begin
        res[0] = (n >= 3) ? clamp_shift(y16 + 32768, 16) : smp[0];
        res[1] = 8'd0;
        res[2] = 8'd0;
        res[3] = 8'd0;
        n = 1;
      end
      pca_pkg::MODE_INVERT: begin
        for (int c = 0; c < lim; c++) res[c] = 8'd255 - smp[c];
      end
      default: ;
    endcase
    o.r0 = res[0];
    o.r1 = res[1];
    o.r2 = res[2];
    o.r3 = res[3];
    o.channels = 3'(n);
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Biased sample: the extremes and mid-gray show up often.
  function automatic logic [7:0] pick_sample();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 8'd0;
    if (sel == 1) return 8'd255;
    if (sel == 2) return 8'd128;
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] pick_pixel();
    return {pick_sample(), pick_sample(), pick_sample(), pick_sample()};
  endfunction

  function automatic logic [15:0] pick_factor();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'd256;
      4, 5: return 16'(int'($urandom_range(1280)) - 256);
      6: return 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends one pixel, with a random gap in front of it when idling is on.
  // tvalid is left high so that the next beat can follow back to back.
  task automatic send_pixel(input logic [31:0] px);
    while (idle_on && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (in_tready !== 1'b1);
    expected_pixels.insert(expected_pixels.size(), predict_pixel(px));
    pixels_sent++;
  endtask

  // Waits until every expected pixel has come out and the pipeline is empty.
  task automatic finish_pending();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drives one register write; cfg_we is left high for a following write.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      pca_pkg::CFG_MODE:     cur_mode = val[2:0];
      pca_pkg::CFG_FACTOR:   cur_factor = val;
      pca_pkg::CFG_CHANNELS: cur_chans = val[2:0];
      default: ;
    endcase
  endtask

  // Registers change only while the block is idle.
  task automatic set_config(input logic [2:0] m, input logic [15:0] f, input logic [2:0] n);
    finish_pending();
    write_reg(pca_pkg::CFG_MODE, {13'd0, m});
    write_reg(pca_pkg::CFG_FACTOR, f);
    write_reg(pca_pkg::CFG_CHANNELS, {13'd0, n});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_config();
    logic [2:0] m;
    logic [2:0] n;
    m = ($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(7));
    n = ($urandom_range(9) < 8) ? 3'(1 + $urandom_range(3)) : 3'($urandom_range(7));
    set_config(m, pick_factor(), n);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random back-pressure, result check and stall watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk) out_tready <= idle_on ? ($urandom_range(99) >= 38) : 1'b1;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    pixel_out_t got;
    pixel_out_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = out_tdata[34:0];
      if (expected_pixels.size() == 0) begin
        report_mismatch("unrequested output beat", int'(got.r0), -1);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (got.r0 !== want.r0) report_mismatch("result0", int'(got.r0), int'(want.r0));
        if (got.r1 !== want.r1) report_mismatch("result1", int'(got.r1), int'(want.r1));
        if (got.r2 !== want.r2) report_mismatch("result2", int'(got.r2), int'(want.r2));
        if (got.r3 !== want.r3) report_mismatch("result3", int'(got.r3), int'(want.r3));
        if (got.channels !== want.channels)
          report_mismatch("result_channels", int'(got.channels), int'(want.channels));
      end
    end
  end

  // Any beat on either side counts as progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("pixel_color_adjust_tb: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: brightness with a factor of 1.0 on four channels.
  task automatic test_reset_state();
    send_pixel(32'h0000_0000);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h01c0_4080);
  endtask

  // Largest and most negative factor; two-channel pixels scale channel 1 too.
  task automatic test_brightness();
    set_config(pca_pkg::MODE_BRIGHT, 16'h7fff, 3'd4);
    send_pixel(32'h017f_80ff);
    set_config(pca_pkg::MODE_BRIGHT, 16'h8000, 3'd4);
    send_pixel(32'h80ff_01ff);
    set_config(pca_pkg::MODE_BRIGHT, 16'd384, 3'd2);
    send_pixel(32'hc0c0_c0c0);
  endtask

  task automatic test_contrast();
    set_config(pca_pkg::MODE_CONTRAST, 16'd512, 3'd3);
    send_pixel(32'h8000_ff00);
    send_pixel(32'h8180_7f12);
  endtask

  // Zero factor gives pure luma; fewer than three channels pass unchanged.
  task automatic test_saturation();
    set_config(pca_pkg::MODE_SAT, 16'h0000, 3'd4);
    send_pixel(32'h1080_ff40);
    set_config(pca_pkg::MODE_SAT, 16'd512, 3'd2);
    send_pixel(32'hddcc_bbaa);
    set_config(pca_pkg::MODE_SAT, 16'hff00, 3'd3);
    send_pixel(32'h00ff_00ff);
  endtask

  // With fewer than three channels the gray value is channel 0 itself.
  task automatic test_grayscale();
    set_config(pca_pkg::MODE_GRAY, 16'd256, 3'd4);
    send_pixel(32'hffff_ffff);
    send_pixel(32'h11ff_00ff);
    set_config(pca_pkg::MODE_GRAY, 16'd256, 3'd2);
    send_pixel(32'h1234_5678);
  endtask

  // Invert across channel counts, including zero and values past four,
  // plus an unused mode code and an out-of-range count in contrast mode.
  task automatic test_invert_and_counts();
    set_config(pca_pkg::MODE_INVERT, 16'd256, 3'd1);
    send_pixel(32'ha5a5_a5a5);
    set_config(pca_pkg::MODE_INVERT, 16'd256, 3'd0);
    send_pixel(32'h0f0f_0f0f);
    set_config(pca_pkg::MODE_INVERT, 16'd256, 3'd7);
    send_pixel(32'h0123_4567);
    set_config(MODE_SPARE, 16'd256, 3'd4);
    send_pixel(32'hdead_beef);
    set_config(pca_pkg::MODE_CONTRAST, 16'd256, 3'd5);
    send_pixel(32'h8080_8080);
  endtask

  // Bursts of random pixels, each under a fresh random configuration.
  task automatic test_random_phases();
    int len;
    while (pixels_sent < 420) begin
      random_config();
      len = 8 + $urandom_range(32);
      repeat (len) send_pixel(pick_pixel());
    end
  endtask

  // A long stretch with no gaps and no back-pressure on either side.
  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (2) begin
      random_config();
      repeat (40) send_pixel(pick_pixel());
    end
    finish_pending();
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_brightness();
    test_contrast();
    test_saturation();
    test_grayscale();
    test_invert_and_counts();
    test_random_phases();
    test_back_to_back();
    finish_pending();
    $display("Run covered %0d pixels, %0d checked, under %0d register settings,",
             pixels_sent, pixels_checked, settings_used);
    $display("all five modes, unused mode codes and out-of-range channel counts.");
    if (mismatches == 0) begin
      $display("pixel_color_adjust_tb: PASS");
    end else begin
      $display("%0d mismatches found", mismatches);
      $display("pixel_color_adjust_tb: FAIL");
    end
    $finish;
  end

endmodule
